/* src/jddm_pkg.sv */
// jddm_pkg: shared constants, register codes and direction codes for the
// joystick differential-drive mixer core
// no dependencies
`timescale 1ns / 1ps

package jddm_pkg;

	// register and field widths
	localparam int CFG_BITS        = 12;
	localparam int SAMPLE_BITS_DEF = 12;
	localparam int CFG_IDX_BITS    = 3;
	localparam int VAL_BITS        = 13;

	// configuration register indexes
	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_CENTER_X   = 3'd0,
		REG_CENTER_Y   = 3'd1,
		REG_DEAD_ZONE  = 3'd2,
		REG_PWM_MAX    = 3'd3,
		REG_PWM_MIN    = 3'd4,
		REG_TURN_LIMIT = 3'd5
	} cfg_idx_t;

	// reset values of the configuration registers
	localparam logic [CFG_BITS-1:0] RST_CENTER_X   = 12'd2048;
	localparam logic [CFG_BITS-1:0] RST_CENTER_Y   = 12'd2048;
	localparam logic [CFG_BITS-1:0] RST_DEAD_ZONE  = 12'd100;
	localparam logic [CFG_BITS-1:0] RST_PWM_MAX    = 12'd1000;
	localparam logic [CFG_BITS-1:0] RST_PWM_MIN    = 12'd0;
	localparam logic [CFG_BITS-1:0] RST_TURN_LIMIT = 12'd300;

	// wheel direction codes
	typedef enum logic [1:0] {
		DIR_OFF = 2'd0,
		DIR_FWD = 2'd1,
		DIR_REV = 2'd2
	} dir_t;

	// axis scaling by 1/1000: divide by 8 with a shift, then reciprocal of 125 with one correction
	localparam int SCALE_DIV   = 1000;
	localparam int SCALE_SHIFT = 3;
	localparam int SCALE_ODD   = SCALE_DIV / (1 << SCALE_SHIFT);
	localparam int P8_BITS     = 19;
	localparam int RECIP_SHIFT = 19;
	localparam int RECIP       = (1 << RECIP_SHIFT) / SCALE_ODD;
	localparam int Q0_BITS     = 13;
	localparam int PROD_BITS   = 32;
	localparam int REM_BITS    = 20;
	// products at or above this always saturate the mapped value
	localparam int BIG_LIMIT   = (1 << CFG_BITS) * SCALE_DIV;

endpackage

/* src/joystick_differential_drive_mixer_core.sv */
// joystick_differential_drive_mixer_core: pipelined arcade-drive mixer, from raw
// joystick samples to wheel direction and duty
// depends on jddm_pkg
//
//  channel | signals                                    | direction
//  --------+--------------------------------------------+----------
//  in      | in_valid, in_ready, sample_x, sample_y      | to block
//  out     | out_valid, out_ready, speed, turn,          | from block
//          | left_dir, left_duty, right_dir, right_duty, |
//          | stopped                                     |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data   | to block
//
// one item per cycle while the output is not stalled; CFG_BITS + 7 register stages,
// among them the turn divider, which resolves one quotient bit per pipeline stage
// reset clears all stage valid bits and loads the register reset values
// a stall holds only stages that are full: an empty stage still takes an item,
// so a new item is taken while a finished result waits at the output
`timescale 1ns / 1ps

module joystick_differential_drive_mixer_core #(
	parameter int SAMPLE_BITS = jddm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// input samples
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [SAMPLE_BITS-1:0]                sample_x,
	input  logic [SAMPLE_BITS-1:0]                sample_y,
	// results
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [jddm_pkg::VAL_BITS-1:0]  speed,
	output logic signed [jddm_pkg::VAL_BITS-1:0]  turn,
	output logic [1:0]                            left_dir,
	output logic [jddm_pkg::CFG_BITS-1:0]         left_duty,
	output logic [1:0]                            right_dir,
	output logic [jddm_pkg::CFG_BITS-1:0]         right_duty,
	output logic                                  stopped,
	// configuration writes
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [jddm_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [jddm_pkg::CFG_BITS-1:0]         cfg_data
);

	localparam int CB        = jddm_pkg::CFG_BITS;
	localparam int VB        = jddm_pkg::VAL_BITS;
	localparam int MW        = (SAMPLE_BITS > CB) ? SAMPLE_BITS : CB;
	localparam int PW        = MW + CB;
	localparam int DIV_STEPS = CB;
	localparam int ST_S4     = 3;
	localparam int ST_S5     = 4;
	localparam int ST_DIV0   = 5;
	localparam int ST_MIX    = ST_DIV0 + DIV_STEPS;
	localparam int ST_OUT    = ST_MIX + 1;
	localparam int NS        = ST_OUT + 1;

	typedef struct packed {
		logic [CB-1:0]        rem;
		logic [CB-1:0]        lo;
		logic [CB-1:0]        quo;
		logic [CB-1:0]        dvs;
		logic                 lim;
		logic                 yneg;
		logic signed [VB-1:0] x;
		logic signed [VB-1:0] y;
		logic                 halt;
	} div_t;

	typedef struct packed {
		jddm_pkg::dir_t dir;
		logic [CB-1:0]  duty;
	} whl_t;

	// clamp one wheel value and split it into direction and duty
	function automatic whl_t wheel(input logic signed [VB-1:0] x,
		input logic signed [VB:0] v, input logic [CB-1:0] top);
		logic signed [VB:0] c;
		logic signed [VB:0] tp;
		logic [VB:0]        m;
		whl_t               w;
		c = v;
		if (x > 0 && v < 0) c = '0;
		if (x < 0 && v > 0) c = '0;
		tp = $signed({2'b00, top});
		if (c > tp) c = tp;
		if (c < -tp) c = -tp;
		m = c[VB] ? (VB+1)'(-c) : (VB+1)'(c);
		w.dir  = (c > 0) ? jddm_pkg::DIR_FWD : ((c < 0) ? jddm_pkg::DIR_REV : jddm_pkg::DIR_OFF);
		w.duty = m[CB-1:0];
		return w;
	endfunction

	// configuration registers
	logic [CB-1:0] center_x_q, center_y_q, dead_zone_q, pwm_max_q, pwm_min_q, turn_limit_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q   <= jddm_pkg::RST_CENTER_X;
			center_y_q   <= jddm_pkg::RST_CENTER_Y;
			dead_zone_q  <= jddm_pkg::RST_DEAD_ZONE;
			pwm_max_q    <= jddm_pkg::RST_PWM_MAX;
			pwm_min_q    <= jddm_pkg::RST_PWM_MIN;
			turn_limit_q <= jddm_pkg::RST_TURN_LIMIT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				jddm_pkg::REG_CENTER_X:   center_x_q   <= cfg_data;
				jddm_pkg::REG_CENTER_Y:   center_y_q   <= cfg_data;
				jddm_pkg::REG_DEAD_ZONE:  dead_zone_q  <= cfg_data;
				jddm_pkg::REG_PWM_MAX:    pwm_max_q    <= cfg_data;
				jddm_pkg::REG_PWM_MIN:    pwm_min_q    <= cfg_data;
				jddm_pkg::REG_TURN_LIMIT: turn_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage valid bits and backward ready chain
	logic [NS-1:0] stg_vld_q;
	logic [NS-1:0] stg_rdy;

	always_comb begin
		stg_rdy[NS-1] = !stg_vld_q[NS-1] || out_ready;
		for (int k = NS - 2; k >= 0; k--) begin
			stg_rdy[k] = !stg_vld_q[k] || stg_rdy[k+1];
		end
	end

	assign in_ready  = stg_rdy[0];
	assign out_valid = stg_vld_q[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_vld_q <= '0;
		end else begin
			if (stg_rdy[0]) stg_vld_q[0] <= in_valid;
			for (int k = 1; k < NS; k++) begin
				if (stg_rdy[k]) stg_vld_q[k] <= stg_vld_q[k-1];
			end
		end
	end

	// axis lanes, stages 1 to 4: centre, dead zone, scale, lift and clamp
	logic [MW-1:0]                    mag_s1 [2];
	logic                             neg_s1 [2];
	logic                             dz_s1  [2];
	logic [PW-1:0]                    prod_s2 [2];
	logic                             neg_s2 [2];
	logic                             dz_s2  [2];
	logic [jddm_pkg::P8_BITS-1:0]     p8_s3  [2];
	logic [jddm_pkg::Q0_BITS-1:0]     q0_s3  [2];
	logic                             big_s3 [2];
	logic                             neg_s3 [2];
	logic                             dz_s3  [2];
	logic signed [VB-1:0]             ax_s4  [2];

	for (genvar a = 0; a < 2; a++) begin : g_axis
		logic [SAMPLE_BITS-1:0]        smp;
		logic [CB-1:0]                 ctr;
		logic signed [MW:0]            gap;
		logic [MW:0]                   gap_neg;
		logic [MW-1:0]                 mag;
		logic [jddm_pkg::P8_BITS-1:0]  p8;
		logic [jddm_pkg::PROD_BITS-1:0] rp;
		logic [jddm_pkg::REM_BITS-1:0] q0m;
		logic [jddm_pkg::REM_BITS-1:0] rdiff;
		logic [CB-1:0]                 qv;
		logic [CB-1:0]                 q;
		logic [CB-1:0]                 lifted;
		logic [CB-1:0]                 clamped;
		logic [CB-1:0]                 v;

		assign smp = (a == 0) ? sample_x : sample_y;
		assign ctr = (a == 0) ? center_x_q : center_y_q;

		// stage 1: signed gap from centre and dead-zone test
		always_comb begin
			gap     = $signed({1'b0, MW'(smp)}) - $signed({1'b0, MW'(ctr)});
			gap_neg = (MW+1)'(-gap);
			mag     = gap[MW] ? gap_neg[MW-1:0] : gap[MW-1:0];
		end

		always_ff @(posedge clk) begin
			if (stg_rdy[0]) begin
				mag_s1[a] <= mag;
				neg_s1[a] <= gap[MW];
				dz_s1[a]  <= mag < MW'(dead_zone_q);
			end
		end

		// stage 2: magnitude times full scale
		always_ff @(posedge clk) begin
			if (stg_rdy[1]) begin
				prod_s2[a] <= PW'(mag_s1[a]) * PW'(pwm_max_q);
				neg_s2[a]  <= neg_s1[a];
				dz_s2[a]   <= dz_s1[a];
			end
		end

		// stage 3: divide by 8, estimate the quotient by 125 with a reciprocal
		always_comb begin
			p8 = prod_s2[a][jddm_pkg::SCALE_SHIFT+jddm_pkg::P8_BITS-1:jddm_pkg::SCALE_SHIFT];
			rp = jddm_pkg::PROD_BITS'(p8) * jddm_pkg::PROD_BITS'(jddm_pkg::RECIP);
		end

		always_ff @(posedge clk) begin
			if (stg_rdy[2]) begin
				p8_s3[a]  <= p8;
				q0_s3[a]  <= rp[jddm_pkg::RECIP_SHIFT+jddm_pkg::Q0_BITS-1:jddm_pkg::RECIP_SHIFT];
				big_s3[a] <= prod_s2[a] >= PW'(jddm_pkg::BIG_LIMIT);
				neg_s3[a] <= neg_s2[a];
				dz_s3[a]  <= dz_s2[a];
			end
		end

		// stage 4: correct the estimate, lift to pwm_min, clamp, negate
		always_comb begin
			q0m     = jddm_pkg::REM_BITS'(q0_s3[a]) * jddm_pkg::REM_BITS'(jddm_pkg::SCALE_ODD);
			rdiff   = jddm_pkg::REM_BITS'(p8_s3[a]) - q0m;
			qv      = q0_s3[a][CB-1:0] + CB'(rdiff >= jddm_pkg::REM_BITS'(jddm_pkg::SCALE_ODD));
			q       = big_s3[a] ? '1 : qv;
			lifted  = (q != '0 && q < pwm_min_q) ? pwm_min_q : q;
			clamped = (lifted > pwm_max_q) ? pwm_max_q : lifted;
			v       = dz_s3[a] ? '0 : clamped;
		end

		always_ff @(posedge clk) begin
			if (stg_rdy[ST_S4]) begin
				ax_s4[a] <= neg_s3[a] ? $signed({1'b0, v}) : -$signed({1'b0, v});
			end
		end
	end

	// stage 5: magnitudes, turn limit test and divider numerator
	div_t                 dv_s5;
	logic [CB-1:0]        absx, absy;
	logic [2*CB-1:0]      num;
	logic [VB-1:0]        negx, negy;

	always_comb begin
		negx = VB'(-ax_s4[0]);
		negy = VB'(-ax_s4[1]);
		absx = ax_s4[0][VB-1] ? negx[CB-1:0] : ax_s4[0][CB-1:0];
		absy = ax_s4[1][VB-1] ? negy[CB-1:0] : ax_s4[1][CB-1:0];
		num  = (2*CB)'(absy) * (2*CB)'(turn_limit_q);
	end

	always_ff @(posedge clk) begin
		if (stg_rdy[ST_S5]) begin
			dv_s5.rem  <= num[2*CB-1:CB];
			dv_s5.lo   <= num[CB-1:0];
			dv_s5.quo  <= '0;
			dv_s5.dvs  <= absx;
			dv_s5.lim  <= absx > turn_limit_q;
			dv_s5.yneg <= ax_s4[1][VB-1];
			dv_s5.x    <= ax_s4[0];
			dv_s5.y    <= ax_s4[1];
			dv_s5.halt <= (ax_s4[0] == '0) && (ax_s4[1] == '0);
		end
	end

	// turn divider: one restoring step per stage, quotient bit by bit
	div_t dv_sd [DIV_STEPS];

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		div_t        src;
		div_t        nxt;
		logic [CB:0] sh;
		logic [CB:0] diff;
		logic        ge;

		if (j == 0) begin : g_first
			assign src = dv_s5;
		end else begin : g_next
			assign src = dv_sd[j-1];
		end

		always_comb begin
			sh   = {src.rem, src.lo[DIV_STEPS-1-j]};
			diff = sh - {1'b0, src.dvs};
			ge   = sh >= {1'b0, src.dvs};
			nxt  = src;
			nxt.rem = ge ? diff[CB-1:0] : sh[CB-1:0];
			nxt.quo[DIV_STEPS-1-j] = ge;
		end

		always_ff @(posedge clk) begin
			if (stg_rdy[ST_DIV0+j]) dv_sd[j] <= nxt;
		end
	end

	// mix stage: limited turn, left and right sums
	logic signed [VB-1:0] x_s18, y_s18;
	logic signed [VB:0]   left_s18, right_s18;
	logic                 halt_s18;
	div_t                 dv_last;
	logic signed [VB-1:0] yq, yf;

	always_comb begin
		dv_last = dv_sd[DIV_STEPS-1];
		yq      = $signed({1'b0, dv_last.quo});
		yf      = dv_last.lim ? (dv_last.yneg ? -yq : yq) : dv_last.y;
	end

	always_ff @(posedge clk) begin
		if (stg_rdy[ST_MIX]) begin
			x_s18     <= dv_last.x;
			y_s18     <= yf;
			left_s18  <= $signed({dv_last.x[VB-1], dv_last.x}) + $signed({yf[VB-1], yf});
			right_s18 <= $signed({dv_last.x[VB-1], dv_last.x}) - $signed({yf[VB-1], yf});
			halt_s18  <= dv_last.halt;
		end
	end

	// output stage: travel-direction guard, clamp, direction and duty
	whl_t                 lw, rw;
	logic signed [VB-1:0] speed_s19, turn_s19;
	whl_t                 left_s19, right_s19;
	logic                 stop_s19;

	assign lw = wheel(x_s18, left_s18, pwm_max_q);
	assign rw = wheel(x_s18, right_s18, pwm_max_q);

	always_ff @(posedge clk) begin
		if (stg_rdy[ST_OUT]) begin
			speed_s19 <= x_s18;
			turn_s19  <= y_s18;
			left_s19  <= lw;
			right_s19 <= rw;
			stop_s19  <= halt_s18;
		end
	end

	assign speed      = speed_s19;
	assign turn       = turn_s19;
	assign left_dir   = left_s19.dir;
	assign left_duty  = left_s19.duty;
	assign right_dir  = right_s19.dir;
	assign right_duty = right_s19.duty;
	assign stopped    = stop_s19;

`ifndef SYNTHESIS
	// stopped items carry a zero speed
	a_stop_speed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stopped |-> speed == '0)
		else $error("stopped item with nonzero speed");

	// forward travel never drives a wheel in reverse
	a_fwd_guard: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !speed[VB-1] && speed != '0 |->
		left_dir != jddm_pkg::DIR_REV && right_dir != jddm_pkg::DIR_REV)
		else $error("wheel reverses against forward travel");

	// a full mix stage that cannot move keeps its item
	a_mix_hold: assert property (@(posedge clk) disable iff (!arst_n)
		stg_vld_q[ST_MIX] && !stg_rdy[ST_MIX] |=> stg_vld_q[ST_MIX])
		else $error("mix stage item lost during stall");

	// input backpressure only when the output is stalled
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input refused while output is free");
`endif

endmodule

/* verif/tb_joystick_differential_drive_mixer_core.sv */
// tb_joystick_differential_drive_mixer_core: self-checking bench for the arcade-drive mixer,
// predicts speed, turn and wheel outputs per sample pair and compares them in order
// depends on jddm_pkg and joystick_differential_drive_mixer_core
`timescale 1ns / 1ps

module tb_joystick_differential_drive_mixer_core;

	localparam int CB           = jddm_pkg::CFG_BITS;
	localparam int SB           = jddm_pkg::SAMPLE_BITS_DEF;
	localparam int VB           = jddm_pkg::VAL_BITS;
	localparam int IB           = jddm_pkg::CFG_IDX_BITS;
	localparam int DUTY_SCALE   = 1000;
	localparam int PIPE_LATENCY = 7 + jddm_pkg::CFG_BITS;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int BLOCK_ITEMS  = 100;
	localparam int MAX_REPORTS  = 10;
	localparam int FULL         = (1 << jddm_pkg::CFG_BITS) - 1;

	// register indexes the block does not decode
	localparam logic [IB-1:0] REG_SPARE_A = 3'd6;
	localparam logic [IB-1:0] REG_SPARE_B = 3'd7;

	typedef struct {
		logic signed [VB-1:0] speed;
		logic signed [VB-1:0] turn;
		jddm_pkg::dir_t       left_dir;
		logic [CB-1:0]        left_duty;
		jddm_pkg::dir_t       right_dir;
		logic [CB-1:0]        right_duty;
		logic                 stopped;
	} wheel_result_t;

	logic                              clk;
	logic                              arst_n;
	logic                              in_valid;
	logic                              in_ready;
	logic [SB-1:0]                     sample_x;
	logic [SB-1:0]                     sample_y;
	logic                              out_valid;
	logic                              out_ready;
	logic signed [VB-1:0]              speed;
	logic signed [VB-1:0]              turn;
	logic [1:0]                        left_dir;
	logic [CB-1:0]                     left_duty;
	logic [1:0]                        right_dir;
	logic [CB-1:0]                     right_duty;
	logic                              stopped;
	logic                              cfg_valid;
	logic                              cfg_ready;
	logic [IB-1:0]                     cfg_index;
	logic [CB-1:0]                     cfg_data;

	// mirrored register settings
	logic [CB-1:0] set_center_x;
	logic [CB-1:0] set_center_y;
	logic [CB-1:0] set_dead_zone;
	logic [CB-1:0] set_pwm_max;
	logic [CB-1:0] set_pwm_min;
	logic [CB-1:0] set_turn_limit;

	wheel_result_t pending_wheels[$];
	int            fail_count;
	int            results_seen;
	int            cycle_count;
	int            in_idle_pct;
	int            out_idle_pct;

	joystick_differential_drive_mixer_core #(
		.SAMPLE_BITS(SB)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample_x   (sample_x),
		.sample_y   (sample_y),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.speed      (speed),
		.turn       (turn),
		.left_dir   (left_dir),
		.left_duty  (left_duty),
		.right_dir  (right_dir),
		.right_duty (right_duty),
		.stopped    (stopped),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	// map one axis: dead zone, scale by pwm_max/1000, lift to pwm_min, clamp
	function automatic int scale_axis(logic [SB-1:0] sample, logic [CB-1:0] center);
		int s;
		int c;
		int gap;
		int mag;
		int top;
		int low;
		int v;
		s = int'(sample);
		c = int'(center);
		top = int'(set_pwm_max);
		low = int'(set_pwm_min);
		gap = s - c;
		mag = (gap < 0) ? -gap : gap;
		if (mag < int'(set_dead_zone))
			return 0;
		v = (gap * top) / DUTY_SCALE;
		if (v > 0 && v < low)
			v = low;
		if (v < 0 && v > -low)
			v = -low;
		if (v > top)
			v = top;
		if (v < -top)
			v = -top;
		return v;
	endfunction

	// wheel value to direction code and duty
	function automatic void split_wheel(int v, output jddm_pkg::dir_t dir,
		output logic [CB-1:0] duty);
		int m;
		m = (v < 0) ? -v : v;
		if (m > int'(set_pwm_max))
			m = int'(set_pwm_max);
		if (v > 0)
			dir = jddm_pkg::DIR_FWD;
		else if (v < 0)
			dir = jddm_pkg::DIR_REV;
		else
			dir = jddm_pkg::DIR_OFF;
		duty = m[CB-1:0];
	endfunction

	// arcade mix of one sample pair under the current settings
	function automatic wheel_result_t mix_wheels(logic [SB-1:0] sx, logic [SB-1:0] sy);
		wheel_result_t r;
		int x;
		int y;
		int ax;
		int top;
		int tl;
		int left_v;
		int right_v;
		top = int'(set_pwm_max);
		tl = int'(set_turn_limit);
		x = -scale_axis(sx, set_center_x);
		y = -scale_axis(sy, set_center_y);
		ax = (x < 0) ? -x : x;
		r.stopped = (x == 0 && y == 0);
		if (ax > tl)
			y = (y * tl) / ax;
		left_v = x + y;
		right_v = x - y;
		// no wheel turns against the direction of travel
		if (x > 0) begin
			if (left_v < 0) left_v = 0;
			if (right_v < 0) right_v = 0;
		end else if (x < 0) begin
			if (left_v > 0) left_v = 0;
			if (right_v > 0) right_v = 0;
		end
		if (left_v > top) left_v = top;
		if (left_v < -top) left_v = -top;
		if (right_v > top) right_v = top;
		if (right_v < -top) right_v = -top;
		r.speed = x[VB-1:0];
		r.turn = y[VB-1:0];
		split_wheel(left_v, r.left_dir, r.left_duty);
		split_wheel(right_v, r.right_dir, r.right_duty);
		return r;
	endfunction

	// compare one output field
	task automatic check_field(string fname, int expv, int actv);
		if (expv != actv) begin
			if (fail_count < MAX_REPORTS)
				$display("mismatch item %0d %s: expected %0d actual %0d",
					results_seen, fname, expv, actv);
			fail_count++;
		end
	endtask

	// receiver stalls
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			out_ready <= ($urandom_range(99) >= out_idle_pct);
		end
	end

	// result checker
	initial begin
		wheel_result_t exp_r;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (pending_wheels.size() == 0) begin
					if (fail_count < MAX_REPORTS)
						$display("result %0d arrived with no item outstanding", results_seen);
					fail_count++;
				end else begin
					exp_r = pending_wheels.pop_front();
					check_field("speed", exp_r.speed, speed);
					check_field("turn", exp_r.turn, turn);
					check_field("left_dir", exp_r.left_dir, left_dir);
					check_field("left_duty", exp_r.left_duty, left_duty);
					check_field("right_dir", exp_r.right_dir, right_dir);
					check_field("right_duty", exp_r.right_duty, right_duty);
					check_field("stopped", exp_r.stopped, stopped);
				end
				results_seen++;
			end
		end
	end

	// send one sample pair and record its expected outputs
	task automatic send_sample(logic [SB-1:0] sx, logic [SB-1:0] sy);
		if ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
		end
		in_valid <= 1'b1;
		sample_x <= sx;
		sample_y <= sy;
		do @(posedge clk); while (!in_ready);
		pending_wheels.push_back(mix_wheels(sx, sy));
	endtask

	// stop sending and let the pipeline empty
	task automatic settle_pipeline();
		in_valid <= 1'b0;
		while (pending_wheels.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 4) @(posedge clk);
	endtask

	// one register write, valid left high for the caller to lower
	task automatic write_reg(logic [IB-1:0] idx, logic [CB-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			jddm_pkg::REG_CENTER_X:   set_center_x = val;
			jddm_pkg::REG_CENTER_Y:   set_center_y = val;
			jddm_pkg::REG_DEAD_ZONE:  set_dead_zone = val;
			jddm_pkg::REG_PWM_MAX:    set_pwm_max = val;
			jddm_pkg::REG_PWM_MIN:    set_pwm_min = val;
			jddm_pkg::REG_TURN_LIMIT: set_turn_limit = val;
			default: ;
		endcase
	endtask

	// idle the block, then load all six registers
	task automatic apply_settings(int cx, int cy, int dz, int pmax, int pmin, int tl);
		settle_pipeline();
		write_reg(jddm_pkg::REG_CENTER_X, CB'(cx));
		write_reg(jddm_pkg::REG_CENTER_Y, CB'(cy));
		write_reg(jddm_pkg::REG_DEAD_ZONE, CB'(dz));
		write_reg(jddm_pkg::REG_PWM_MAX, CB'(pmax));
		write_reg(jddm_pkg::REG_PWM_MIN, CB'(pmin));
		write_reg(jddm_pkg::REG_TURN_LIMIT, CB'(tl));
		cfg_valid <= 1'b0;
	endtask

	// reset settings: rest, corners, dead zone edges, turn limiting, reversal guard
	task automatic test_reset_defaults();
		send_sample(12'd2048, 12'd2048);
		send_sample(12'd0, 12'd0);
		send_sample(12'd4095, 12'd4095);
		send_sample(12'd0, 12'd4095);
		send_sample(12'd4095, 12'd0);
		send_sample(12'd2147, 12'd1949);
		send_sample(12'd2148, 12'd1948);
		send_sample(12'd2048, 12'd0);
		send_sample(12'd1898, 12'd0);
		send_sample(12'd4095, 12'd2148);
	endtask

	// corner settings
	task automatic test_corner_settings();
		// pwm_min above pwm_max
		apply_settings(2048, 2048, 100, 500, 700, 300);
		send_sample(12'd2148, 12'd1900);
		send_sample(12'd0, 12'd4095);
		// pwm_max zero always stops
		apply_settings(2048, 2048, 100, 0, 0, 300);
		send_sample(12'd0, 12'd4095);
		send_sample(12'd4095, 12'd2048);
		// no dead zone, a gap of zero is still scaled
		apply_settings(2048, 2048, 0, 1000, 0, 300);
		send_sample(12'd2048, 12'd2048);
		send_sample(12'd2049, 12'd2047);
		// zero turn limit and lifting to pwm_min
		apply_settings(2048, 2048, 100, 1000, 200, 0);
		send_sample(12'd0, 12'd0);
		send_sample(12'd2048, 12'd0);
		send_sample(12'd2148, 12'd2248);
		// all registers at their extremes
		apply_settings(0, FULL, 0, FULL, FULL, FULL);
		send_sample(12'd4095, 12'd0);
		send_sample(12'd0, 12'd4095);
		send_sample(12'd0, 12'd0);
	endtask

	// writes to undecoded indexes change nothing
	task automatic test_spare_index();
		settle_pipeline();
		write_reg(REG_SPARE_A, 12'h0AB);
		write_reg(REG_SPARE_B, 12'hFFF);
		cfg_valid <= 1'b0;
		send_sample(12'd0, 12'd4095);
		send_sample(12'd4095, 12'd0);
	endtask

	// sample biased toward the centre, the rails or the whole range
	function automatic logic [SB-1:0] pick_sample(int center, int dz);
		int v;
		case ($urandom_range(3))
			1: v = center - (dz + 60) + int'($urandom_range(2 * (dz + 60)));
			2: v = $urandom_range(1) ? int'($urandom_range(63)) : FULL - int'($urandom_range(63));
			default: v = int'($urandom_range(FULL));
		endcase
		if (v < 0) v = 0;
		if (v > FULL) v = FULL;
		return v[SB-1:0];
	endfunction

	// random settings per block of items, three idling modes
	task automatic test_random_traffic();
		int pmax;
		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin in_idle_pct = 12; out_idle_pct = 60; end
				1: begin in_idle_pct = 60; out_idle_pct = 12; end
				default: begin in_idle_pct = 0; out_idle_pct = 0; end
			endcase
			for (int blk = 0; blk < 6; blk++) begin
				case ($urandom_range(5))
					0: apply_settings(jddm_pkg::RST_CENTER_X, jddm_pkg::RST_CENTER_Y,
						jddm_pkg::RST_DEAD_ZONE, jddm_pkg::RST_PWM_MAX,
						jddm_pkg::RST_PWM_MIN, jddm_pkg::RST_TURN_LIMIT);
					1: apply_settings($urandom_range(1) ? FULL : 0, $urandom_range(1) ? FULL : 0,
						0, FULL, int'($urandom_range(FULL)), $urandom_range(1) ? FULL : 0);
					2: apply_settings(int'($urandom_range(FULL)), int'($urandom_range(FULL)),
						0, 0, 0, 0);
					default: begin
						pmax = int'($urandom_range(FULL));
						apply_settings(int'($urandom_range(1500, 2600)),
							int'($urandom_range(1500, 2600)),
							int'($urandom_range(400)), pmax,
							int'($urandom_range((pmax + 100 > FULL) ? FULL : pmax + 100)),
							int'($urandom_range(FULL)));
					end
				endcase
				for (int n = 0; n < BLOCK_ITEMS; n++)
					send_sample(pick_sample(int'(set_center_x), int'(set_dead_zone)),
						pick_sample(int'(set_center_y), int'(set_dead_zone)));
			end
		end
	endtask

	// main sequence
	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		sample_x <= '0;
		sample_y <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		set_center_x = jddm_pkg::RST_CENTER_X;
		set_center_y = jddm_pkg::RST_CENTER_Y;
		set_dead_zone = jddm_pkg::RST_DEAD_ZONE;
		set_pwm_max = jddm_pkg::RST_PWM_MAX;
		set_pwm_min = jddm_pkg::RST_PWM_MIN;
		set_turn_limit = jddm_pkg::RST_TURN_LIMIT;
		fail_count = 0;
		results_seen = 0;
		in_idle_pct = 12;
		out_idle_pct = 60;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_corner_settings();
		test_spare_index();
		test_random_traffic();

		settle_pipeline();
		if (fail_count == 0 && pending_wheels.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
